>>> hw/rtl/sil_pkg.sv
// ----------------------------------------------------------------------------
// sil_pkg
// Shared types and codes for the sorted insert list: request actions, result
// status codes, sequencer states and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package sil_pkg;

  localparam int unsigned ValW    = 32;
  localparam int unsigned ActionW = 2;
  localparam int unsigned StatusW = 3;

  typedef enum logic [ActionW-1:0] {
    ACT_INSERT = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [StatusW-1:0] {
    STS_INSERTED = 3'd0,
    STS_FULL     = 3'd1,
    STS_ELEMENT  = 3'd2,
    STS_EMPTY    = 3'd3,
    STS_CLEARED  = 3'd4
  } status_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_READ
  } seq_state_e;

  // control broadcast to every cell in the chain
  typedef struct packed {
    logic                   ins;  // insert key in order
    logic                   rot;  // rotate occupied cells toward the head
    logic signed [ValW-1:0] key;  // value being inserted
  } cell_ctrl_t;

endpackage

>>> hw/rtl/sil_cell.sv
// ----------------------------------------------------------------------------
// sil_cell
// One slot of the sorted chain. Compares the broadcast key against its value,
// shifts up on insert, and rotates toward the head during read out.
// ----------------------------------------------------------------------------
module sil_cell
  import sil_pkg::*;
(
  input  logic                   clk_i,
  input  cell_ctrl_t             ctrl_i,
  input  logic                   occ_i,       // this slot holds a value
  input  logic                   prev_ge_i,   // lower neighbor moves up
  input  logic signed [ValW-1:0] prev_val_i,
  input  logic                   next_occ_i,  // upper neighbor holds a value
  input  logic signed [ValW-1:0] next_val_i,
  input  logic signed [ValW-1:0] head_val_i,
  output logic signed [ValW-1:0] val_o,
  output logic                   ge_o         // slot is empty or value >= key
);

  logic signed [ValW-1:0] val_q, val_d;

  assign ge_o  = !occ_i || (val_q >= ctrl_i.key);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins && ge_o) begin
      val_d = prev_ge_i ? prev_val_i : ctrl_i.key;
    end else if (ctrl_i.rot) begin
      // the topmost occupied slot wraps around to the old head
      val_d = next_occ_i ? next_val_i : head_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

>>> hw/rtl/sorted_insert_list.sv
// ----------------------------------------------------------------------------
// sorted_insert_list
// Bounded ascending store of signed 32-bit values built as a chain of cells.
// ----------------------------------------------------------------------------
// channel  dir  tdata             tuser          tlast
// s_axis   in   value[31:0]       action[1:0]    -
// m_axis   out  item_value[31:0]  status[2:0]    last
//
// Insert, clear and empty read out register a result as the request is taken;
// the key is compared in every cell at once and the chain shifts in the same
// cycle. After the request, read out gives one value per cycle while the
// output register is free, rotating the chain through the head cell. A result
// waits in the output register; a request is taken when it is free and no
// read out runs. Reset empties the store (count only) and clears output valid.
// ----------------------------------------------------------------------------
module sorted_insert_list
  import sil_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,   // value[31:0]
  input  logic [1:0]    s_axis_tuser,   // action[1:0]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [31:0]   m_axis_tdata,   // item_value[31:0]
  output logic [2:0]    m_axis_tuser,   // status[2:0]
  output logic          m_axis_tlast    // last
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  seq_state_e             state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic                   ovld_q, ovld_d;
  logic signed [ValW-1:0] odata_q, odata_d;
  status_e                osts_q, osts_d;
  logic                   olast_q, olast_d;

  cell_ctrl_t             ctrl;
  logic [CAPACITY-1:0]    occ;
  logic [CAPACITY-1:0]    ge;
  logic signed [ValW-1:0] vals [CAPACITY];

  logic    slot_free;
  logic    req;
  action_e act;
  logic    full;

  assign slot_free = !ovld_q || m_axis_tready;
  assign act       = action_e'(s_axis_tuser);
  assign req       = s_axis_tvalid && s_axis_tready;
  assign full      = (cnt_q >= CntW'(CAPACITY));

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (cnt_q > CntW'(i));
    if (i == 0) begin : g_head
      sil_cell u_cell (
        .clk_i,
        .ctrl_i     (ctrl),
        .occ_i      (occ[i]),
        .prev_ge_i  (1'b0),
        .prev_val_i (ctrl.key),
        .next_occ_i (occ[i+1]),
        .next_val_i (vals[i+1]),
        .head_val_i (vals[0]),
        .val_o      (vals[i]),
        .ge_o       (ge[i])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      sil_cell u_cell (
        .clk_i,
        .ctrl_i     (ctrl),
        .occ_i      (occ[i]),
        .prev_ge_i  (ge[i-1]),
        .prev_val_i (vals[i-1]),
        .next_occ_i (1'b0),
        .next_val_i (ctrl.key),
        .head_val_i (vals[0]),
        .val_o      (vals[i]),
        .ge_o       (ge[i])
      );
    end else begin : g_mid
      sil_cell u_cell (
        .clk_i,
        .ctrl_i     (ctrl),
        .occ_i      (occ[i]),
        .prev_ge_i  (ge[i-1]),
        .prev_val_i (vals[i-1]),
        .next_occ_i (occ[i+1]),
        .next_val_i (vals[i+1]),
        .head_val_i (vals[0]),
        .val_o      (vals[i]),
        .ge_o       (ge[i])
      );
    end
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    ovld_d        = ovld_q && !m_axis_tready;
    odata_d       = odata_q;
    osts_d        = osts_q;
    olast_d       = olast_q;
    ctrl.ins      = 1'b0;
    ctrl.rot      = 1'b0;
    ctrl.key      = $signed(s_axis_tdata);
    s_axis_tready = 1'b0;

    case (state_q)
      SEQ_IDLE: begin
        s_axis_tready = slot_free;
        if (req) begin
          odata_d = '0;
          olast_d = 1'b1;
          case (act)
            ACT_INSERT: begin
              ovld_d = 1'b1;
              if (full) begin
                osts_d = STS_FULL;
              end else begin
                osts_d   = STS_INSERTED;
                ctrl.ins = 1'b1;
                cnt_d    = cnt_q + 1'b1;
              end
            end
            ACT_READ: begin
              if (cnt_q == '0) begin
                ovld_d = 1'b1;
                osts_d = STS_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = SEQ_READ;
              end
            end
            ACT_CLEAR: begin
              ovld_d = 1'b1;
              osts_d = STS_CLEARED;
              cnt_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      SEQ_READ: begin
        if (slot_free) begin
          ovld_d   = 1'b1;
          odata_d  = vals[0];
          osts_d   = STS_ELEMENT;
          olast_d  = (CntW'(idx_q) + 1'b1 == cnt_q);
          ctrl.rot = 1'b1;
          idx_d    = idx_q + 1'b1;
          if (olast_d) begin
            state_d = SEQ_IDLE;
          end
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    osts_q  <= osts_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = osts_q;
  assign m_axis_tlast  = olast_q;

endmodule

>>> hw/rtl/sil_check.sv
// ----------------------------------------------------------------------------
// sil_check
// Port-level checks for the sorted insert list, bound to the top level.
// ----------------------------------------------------------------------------
module sil_check
  import sil_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // every status other than an element is a single, final result
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STS_ELEMENT) |-> m_axis_tlast)
    else $error("non-element result without last");

  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STS_ELEMENT) |-> (m_axis_tdata == '0))
    else $error("status result carries nonzero data");

  // an element run is not interrupted by another status
  a_run_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (m_axis_tuser == STS_ELEMENT) && !m_axis_tlast
    ##1 m_axis_tvalid |-> (m_axis_tuser == STS_ELEMENT))
    else $error("element run broken");

  // no request is taken while a read out run is in progress
  a_no_req_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STS_ELEMENT) && !m_axis_tlast |-> !s_axis_tready)
    else $error("request taken during read out");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind sorted_insert_list sil_check u_sil_check (.*);
